// ----- sv/acs_pkg.sv -----
package acs_pkg;

    typedef struct packed {
        logic [15:0] accel_x;
        logic [15:0] accel_y;
        logic [15:0] accel_z;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] step_count;
        logic        step_detected;
        logic [1:0]  active_axis;
        logic        window_done;
    } out_beat_t;

    typedef struct packed {
        logic [15:0] high;
        logic [15:0] mid;
        logic [15:0] low;
    } limits_t;

    // Per-axis view handed to the merge stage (values zero-extended to 16 bits).
    typedef struct packed {
        logic [15:0] swing;
        logic [15:0] midpoint;
        logic        bad;
        logic [15:0] filt_prev;
        logic [15:0] filt_new;
    } lane_stat_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    // Register map indexes (byte address = 4 * index).
    localparam logic [1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [1:0] REG_HIGH_LIMIT    = 2'd1;
    localparam logic [1:0] REG_MID_LIMIT     = 2'd2;
    localparam logic [1:0] REG_LOW_LIMIT     = 2'd3;

    localparam logic [7:0]  WINDOW_LENGTH_RESET = 8'd50;
    localparam logic [15:0] HIGH_LIMIT_RESET    = 16'd160;
    localparam logic [15:0] MID_LIMIT_RESET     = 16'd50;
    localparam logic [15:0] LOW_LIMIT_RESET     = 16'd15;

    localparam int unsigned SAMPLE_RESET  = 1;
    localparam int unsigned MIN_RESET     = 1000;
    localparam int unsigned MIN_RESTART   = 1023;
    localparam int unsigned SWING_RESET   = 30;
    localparam int unsigned MID_RESET     = 500;
    localparam int unsigned HYST_RESET    = 5;
    localparam int unsigned HYST_MID      = 4;
    localparam int unsigned HYST_LOW      = 3;
    localparam int unsigned HYST_BAD      = 2;
    localparam int unsigned HYST_SHIFT    = 5;

endpackage

// ----- sv/acs_lane.sv -----
module acs_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [15:0]         sample,
    input  logic                load,
    input  logic                update,
    input  logic                close,
    input  acs_pkg::limits_t    limits,
    output acs_pkg::lane_stat_t stat
);

    localparam int SB          = SAMPLE_BITS;
    localparam int SUM_W       = SB + 2;
    localparam int RECIP_SHIFT = SB + 3;
    localparam int RECIP_W     = SB + 2;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int HYST_W      = SB - 5;
    // ceil(2^RECIP_SHIFT / 3): exact floor(sum/3) for sum < 2^RECIP_SHIFT
    localparam longint unsigned RECIP = ((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3;

    logic [SB-1:0]     newest_reg, older_reg;
    logic [SB-1:0]     mean_reg;
    logic [SB-1:0]     wmax_reg, wmin_reg;
    logic [SB-1:0]     swing_reg, mid_reg;
    logic [HYST_W-1:0] hyst_reg;
    logic              bad_reg;
    logic [SB-1:0]     filt_reg;

    logic [SB-1:0]     s;
    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;
    logic [SB-1:0]     mean_next;

    logic [SB-1:0]     wmax_upd, wmin_upd;
    logic [SB-1:0]     wmax_next, wmin_next;
    logic [SB-1:0]     swing_new, mid_new;
    logic [15:0]       swing_ext;
    logic [HYST_W-1:0] hyst_new;
    logic              bad_new;
    logic [SB-1:0]     swing_next, mid_next;
    logic [HYST_W-1:0] hyst_next;
    logic              bad_next;
    logic [SB-1:0]     diff;
    logic [SB-1:0]     filt_next;

    // stage 1: three-tap mean by reciprocal multiply
    always_comb begin
        s         = sample[SB-1:0];
        sum       = SUM_W'(s) + SUM_W'(newest_reg) + SUM_W'(older_reg);
        prod      = PROD_W'(sum) * PROD_W'(RECIP_W'(RECIP));
        mean_next = prod[RECIP_SHIFT +: SB];
    end

    // stage 2: window tracking, window close, hysteresis filter
    always_comb begin
        wmax_upd  = (mean_reg > wmax_reg) ? mean_reg : wmax_reg;
        wmin_upd  = (mean_reg < wmin_reg) ? mean_reg : wmin_reg;
        swing_new = (wmax_upd >= wmin_upd) ? wmax_upd - wmin_upd : '0;
        mid_new   = wmin_upd + (swing_new >> 1);
        swing_ext = 16'(swing_new);
        bad_new   = 1'b0;
        priority if (swing_ext >= limits.high) begin
            hyst_new = HYST_W'(swing_new >> acs_pkg::HYST_SHIFT);
        end else if (swing_ext >= limits.mid) begin
            hyst_new = HYST_W'(acs_pkg::HYST_MID);
        end else if (swing_ext >= limits.low) begin
            hyst_new = HYST_W'(acs_pkg::HYST_LOW);
        end else begin
            hyst_new = HYST_W'(acs_pkg::HYST_BAD);
            bad_new  = 1'b1;
        end

        if (close) begin
            wmax_next  = '0;
            wmin_next  = SB'(acs_pkg::MIN_RESTART);
            swing_next = swing_new;
            mid_next   = mid_new;
            hyst_next  = hyst_new;
            bad_next   = bad_new;
        end else begin
            wmax_next  = wmax_upd;
            wmin_next  = wmin_upd;
            swing_next = swing_reg;
            mid_next   = mid_reg;
            hyst_next  = hyst_reg;
            bad_next   = bad_reg;
        end

        diff      = (mean_reg >= filt_reg) ? mean_reg - filt_reg : filt_reg - mean_reg;
        filt_next = (diff >= SB'(hyst_next)) ? mean_reg : filt_reg;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            mean_reg <= mean_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            newest_reg <= SB'(acs_pkg::SAMPLE_RESET);
            older_reg  <= SB'(acs_pkg::SAMPLE_RESET);
            wmax_reg   <= '0;
            wmin_reg   <= SB'(acs_pkg::MIN_RESET);
            swing_reg  <= SB'(acs_pkg::SWING_RESET);
            mid_reg    <= SB'(acs_pkg::MID_RESET);
            hyst_reg   <= HYST_W'(acs_pkg::HYST_RESET);
            bad_reg    <= 1'b0;
            filt_reg   <= '0;
        end else begin
            if (load) begin
                older_reg  <= newest_reg;
                newest_reg <= s;
            end
            if (update) begin
                wmax_reg  <= wmax_next;
                wmin_reg  <= wmin_next;
                swing_reg <= swing_next;
                mid_reg   <= mid_next;
                hyst_reg  <= hyst_next;
                bad_reg   <= bad_next;
                filt_reg  <= filt_next;
            end
        end
    end

    assign stat.swing     = 16'(swing_next);
    assign stat.midpoint  = 16'(mid_next);
    assign stat.bad       = bad_next;
    assign stat.filt_prev = 16'(filt_reg);
    assign stat.filt_new  = 16'(filt_next);

endmodule

// ----- sv/acs_merge.sv -----
module acs_merge (
    input  logic                aclk,
    input  logic                aresetn,
    input  acs_pkg::lane_stat_t stat_x,
    input  acs_pkg::lane_stat_t stat_y,
    input  acs_pkg::lane_stat_t stat_z,
    input  logic                update,
    input  logic                window_done,
    output acs_pkg::out_beat_t  beat
);

    acs_pkg::axis_t      act;
    acs_pkg::lane_stat_t sel;
    logic                step;
    logic [31:0]         steps_reg, steps_next;
    acs_pkg::out_beat_t  beat_reg, beat_next;

    always_comb begin
        // ties: x over y and z, y over z
        priority if (stat_x.swing >= stat_y.swing && stat_x.swing >= stat_z.swing) begin
            act = acs_pkg::AXIS_X;
        end else if (stat_y.swing >= stat_z.swing) begin
            act = acs_pkg::AXIS_Y;
        end else begin
            act = acs_pkg::AXIS_Z;
        end

        unique case (act)
            acs_pkg::AXIS_X: sel = stat_x;
            acs_pkg::AXIS_Y: sel = stat_y;
            acs_pkg::AXIS_Z: sel = stat_z;
            default:         sel = stat_x;
        endcase

        step = (sel.filt_prev >= sel.midpoint) && (sel.filt_new < sel.midpoint) && !sel.bad;
        steps_next = steps_reg + 32'(step);

        beat_next.step_count    = steps_next;
        beat_next.step_detected = step;
        beat_next.active_axis   = act;
        beat_next.window_done   = window_done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg <= '0;
        end else if (update) begin
            steps_reg <= steps_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (update) begin
            beat_reg <= beat_next;
        end
    end

    assign beat = beat_reg;

endmodule

// ----- sv/accelerometer_step_counter.sv -----
// Three-axis pedometer with a dynamic threshold.
// Input channel (s_valid/s_ready/s_data): one beat carries one sample per axis.
// Output channel (m_valid/m_ready/m_data): one beat per input beat, in order,
// with the running step count, the step flag, the active axis and window flag.
// APB port: window length and three swing limits at byte addresses 0,4,8,12;
// pready is tied high, reads return the stored value.
// Pipeline: an accepted beat is registered in stage 1, then moves on to the
// output register, which raises m_valid. Stage 1 holds the three-tap mean
// (reciprocal multiply); stage 2 is the per-sample state update (window
// max/min, window close, hysteresis filter, step decision) and loads the
// output register.
// Throughput: one beat per cycle while m_ready stays high; the stage 2 state
// recurrence is combinational from the state registers back to them.
// Reset (aresetn low, synchronous): registers back to their defaults,
// per-axis history and thresholds to their initial values, pipeline empty.
// Receiver stall: the output register holds its beat, stage 1 can still take
// one more beat, after that s_ready drops until m_ready returns.
module accelerometer_step_counter #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  acs_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output acs_pkg::out_beat_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // config registers
    logic [7:0]       win_len_reg;
    acs_pkg::limits_t limits_reg;
    logic [1:0]       reg_index;
    logic             cfg_wr;

    // pipeline control
    logic             v1_reg, v1_next;
    logic             m_valid_reg, m_valid_next;
    logic             load, adv;

    // sample counter
    logic [7:0]       cnt_reg, cnt_next, cnt_inc;
    logic             close;

    logic [15:0]         lane_sample [3];
    acs_pkg::lane_stat_t lane_stat   [3];

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_wr    = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg     <= acs_pkg::WINDOW_LENGTH_RESET;
            limits_reg.high <= acs_pkg::HIGH_LIMIT_RESET;
            limits_reg.mid  <= acs_pkg::MID_LIMIT_RESET;
            limits_reg.low  <= acs_pkg::LOW_LIMIT_RESET;
        end else if (cfg_wr) begin
            unique case (reg_index)
                acs_pkg::REG_WINDOW_LENGTH: win_len_reg     <= pwdata[7:0];
                acs_pkg::REG_HIGH_LIMIT:    limits_reg.high <= pwdata[15:0];
                acs_pkg::REG_MID_LIMIT:     limits_reg.mid  <= pwdata[15:0];
                acs_pkg::REG_LOW_LIMIT:     limits_reg.low  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            acs_pkg::REG_WINDOW_LENGTH: prdata = 32'(win_len_reg);
            acs_pkg::REG_HIGH_LIMIT:    prdata = 32'(limits_reg.high);
            acs_pkg::REG_MID_LIMIT:     prdata = 32'(limits_reg.mid);
            acs_pkg::REG_LOW_LIMIT:     prdata = 32'(limits_reg.low);
            default:                    prdata = '0;
        endcase
    end

    // stage 1 moves into stage 2 / output register when that slot frees up
    assign adv     = v1_reg && (!m_valid_reg || m_ready);
    assign s_ready = !v1_reg || adv;
    assign load    = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        v1_next      = load ? 1'b1 : (adv ? 1'b0 : v1_reg);
        m_valid_next = adv ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    // window counter: a count at or past the length closes the window
    always_comb begin
        cnt_inc  = cnt_reg + 8'd1;
        close    = (cnt_inc >= win_len_reg);
        cnt_next = close ? 8'd0 : cnt_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            v1_reg      <= v1_next;
            m_valid_reg <= m_valid_next;
            if (adv) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    assign lane_sample[0] = s_data.accel_x;
    assign lane_sample[1] = s_data.accel_y;
    assign lane_sample[2] = s_data.accel_z;

    // one lane per axis
    for (genvar a = 0; a < 3; a++) begin : g_lane
        acs_lane #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .sample  (lane_sample[a]),
            .load    (load),
            .update  (adv),
            .close   (close),
            .limits  (limits_reg),
            .stat    (lane_stat[a])
        );
    end

    acs_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .stat_x      (lane_stat[0]),
        .stat_y      (lane_stat[1]),
        .stat_z      (lane_stat[2]),
        .update      (adv),
        .window_done (close),
        .beat        (m_data)
    );

endmodule
